// File: rtl/rgb565_downscale_gray_gamma_assert.svh
// Assertion macros for the RGB565 downscaler.
// Needs clk and arst_n in the scope of the including module.
`ifndef RGB565_DOWNSCALE_GRAY_GAMMA_ASSERT_SVH
`define RGB565_DOWNSCALE_GRAY_GAMMA_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RDG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define RDG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rdg_pkg.sv
// Shared types, constants and helper functions of the RGB565 downscaler.
// No dependencies; every other file but the assertion header imports it.
package rdg_pkg;

	// Field widths
	localparam int PIXEL_W = 16;
	localparam int GRAY_W  = 8;
	localparam int CH_W    = 5;
	localparam int POS_W   = 6;

	// Default frame geometry
	localparam int SRC_WIDTH_DEF  = 160;
	localparam int SRC_HEIGHT_DEF = 120;
	localparam int DST_WIDTH_DEF  = 64;
	localparam int DST_HEIGHT_DEF = 64;

	// Fixed-point scale of the position mapping
	localparam int MAP_SCALE = 1000;

	// Queue between front and back, power of two
	localparam int QDEPTH = 4;

	// Luma weights (percent) and the reciprocal of 100
	localparam int LUMA_WR    = 30;
	localparam int LUMA_WG    = 59;
	localparam int LUMA_WB    = 11;
	localparam int LUMA_SUM_W = 15;
	localparam int LUMA_RECIP = 5243;
	localparam int LUMA_SHIFT = 19;
	localparam int LUMA_PROD_W = LUMA_SUM_W + 13;

	// Display channel scales
	localparam int SCALE_R     = 36;
	localparam int SCALE_G     = 28;
	localparam int SCALE_B     = 40;
	localparam int SCALE_SHIFT = 5;
	localparam int SCALE_PW    = 11;
	localparam logic [CH_W-1:0] CH_MAX = 5'd31;

	localparam logic [CH_W-1:0] GAMMA_LUT [32] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd3,
		5'd4,  5'd5,  5'd7,  5'd9,  5'd11, 5'd13, 5'd15, 5'd17,
		5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28, 5'd29, 5'd30,
		5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
	};

	// One kept pixel travelling from front to back
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [POS_W-1:0]   out_col;
		logic [POS_W-1:0]   out_row;
		logic               frame_done;
	} rdg_item_t;

	// Scale a 5-bit channel, shift down and clamp to the table range
	function automatic logic [CH_W-1:0] disp_index(logic [CH_W-1:0] ch, int unsigned scale);
		logic [SCALE_PW-1:0] prod;
		logic [SCALE_PW-SCALE_SHIFT-1:0] idx;
		prod = SCALE_PW'(ch) * SCALE_PW'(scale);
		idx  = prod[SCALE_PW-1:SCALE_SHIFT];
		return (idx > (SCALE_PW-SCALE_SHIFT)'(CH_MAX)) ? CH_MAX : idx[CH_W-1:0];
	endfunction

endpackage

// File: rtl/rdg_in_if.sv
// Pixel request channel: valid/ready with RGB565 pixel and frame start flag.
// Depends on rdg_pkg.
interface rdg_in_if;
	import rdg_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               frame_start;

	modport source(output valid, pixel, frame_start, input ready);
	modport sink(input valid, pixel, frame_start, output ready);
endinterface

// File: rtl/rdg_out_if.sv
// Result request channel: valid/ready with luma, display channels and position.
// Depends on rdg_pkg.
interface rdg_out_if;
	import rdg_pkg::*;

	logic              valid;
	logic              ready;
	logic [GRAY_W-1:0] gray;
	logic [CH_W-1:0]   disp_red;
	logic [CH_W-1:0]   disp_green;
	logic [CH_W-1:0]   disp_blue;
	logic [POS_W-1:0]  out_col;
	logic [POS_W-1:0]  out_row;
	logic              frame_done;

	modport source(output valid, gray, disp_red, disp_green, disp_blue,
		out_col, out_row, frame_done, input ready);
	modport sink(input valid, gray, disp_red, disp_green, disp_blue,
		out_col, out_row, frame_done, output ready);
endinterface

// File: rtl/rdg_front.sv
// Front end: counts source position, decides which pixels land on the output grid.
// Depends on rdg_pkg and rdg_in_if; feeds rdg_fifo.
module rdg_front #(
	parameter int SRC_WIDTH  = rdg_pkg::SRC_WIDTH_DEF,
	parameter int SRC_HEIGHT = rdg_pkg::SRC_HEIGHT_DEF,
	parameter int DST_WIDTH  = rdg_pkg::DST_WIDTH_DEF,
	parameter int DST_HEIGHT = rdg_pkg::DST_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rdg_in_if.sink            pix,
	output logic              q_push,
	output rdg_pkg::rdg_item_t q_item,
	input  logic              q_full
);
	import rdg_pkg::*;

	// Mapping steps and widths. A source index c is kept when some d maps to it;
	// the first d past c is ceil((c+1)*SCALE/STEP), tracked as quotient + remainder.
	localparam int XSTEP = SRC_WIDTH * MAP_SCALE / DST_WIDTH;
	localparam int YSTEP = SRC_HEIGHT * MAP_SCALE / DST_HEIGHT;
	localparam int XK    = (MAP_SCALE + XSTEP - 1) / XSTEP;
	localparam int YK    = (MAP_SCALE + YSTEP - 1) / YSTEP;
	localparam int XKW   = $clog2(XK + 1);
	localparam int YKW   = $clog2(YK + 1);
	localparam int XRW   = $clog2((XK + 1) * XSTEP + MAP_SCALE) + 1;
	localparam int YRW   = $clog2((YK + 1) * YSTEP + MAP_SCALE) + 1;
	localparam int XQW   = $clog2(DST_WIDTH + XK + 2) + 1;
	localparam int YQW   = $clog2(DST_HEIGHT + YK + 2) + 1;
	localparam int SCW   = $clog2(SRC_WIDTH);
	localparam int SRW   = $clog2(SRC_HEIGHT);

	logic [SCW-1:0]        src_col_q, scol;
	logic [SRW-1:0]        src_row_q, srow;
	logic [XQW-1:0]        dcol_q, dcol, dcol_nxt;
	logic [YQW-1:0]        drow_q, drow, drow_nxt;
	logic signed [XRW-1:0] crem_q, crem, crem_nxt;
	logic signed [YRW-1:0] rrem_q, rrem, rrem_nxt;
	logic [XKW-1:0]        ck;
	logic [YKW-1:0]        rk;
	logic                  col_hit, row_hit, row_end, frame_end, accept;

	// Frame start clears the position before the pixel is judged
	always_comb begin
		scol = pix.frame_start ? '0 : src_col_q;
		srow = pix.frame_start ? '0 : src_row_q;
		dcol = pix.frame_start ? '0 : dcol_q;
		drow = pix.frame_start ? '0 : drow_q;
		crem = pix.frame_start ? '0 : crem_q;
		rrem = pix.frame_start ? '0 : rrem_q;
	end

	// Column step: smallest k with rem - SCALE + k*STEP >= 0
	always_comb begin : col_step
		logic signed [XRW-1:0] cand;
		ck       = '0;
		crem_nxt = crem;
		for (int k = XK; k >= 0; k--) begin
			cand = crem - XRW'(MAP_SCALE) + XRW'(k * XSTEP);
			if (!cand[XRW-1]) begin
				ck       = XKW'(k);
				crem_nxt = cand;
			end
		end
		dcol_nxt = dcol + XQW'(ck);
		col_hit  = (ck != '0) && (dcol < XQW'(DST_WIDTH));
	end

	// Row step, same scheme on the row axis
	always_comb begin : row_step
		logic signed [YRW-1:0] cand;
		rk       = '0;
		rrem_nxt = rrem;
		for (int k = YK; k >= 0; k--) begin
			cand = rrem - YRW'(MAP_SCALE) + YRW'(k * YSTEP);
			if (!cand[YRW-1]) begin
				rk       = YKW'(k);
				rrem_nxt = cand;
			end
		end
		drow_nxt = drow + YQW'(rk);
		row_hit  = (rk != '0) && (drow < YQW'(DST_HEIGHT));
	end

	// Handshake and queue push
	assign pix.ready = !q_full;
	assign accept    = pix.valid && pix.ready;
	assign q_push    = accept && col_hit && row_hit;
	assign row_end   = (scol == SCW'(SRC_WIDTH - 1));
	assign frame_end = (srow == SRW'(SRC_HEIGHT - 1));

	always_comb begin
		q_item.pixel      = pix.pixel;
		q_item.out_col    = POS_W'(dcol);
		q_item.out_row    = POS_W'(drow);
		q_item.frame_done = (dcol == XQW'(DST_WIDTH - 1)) && (drow == YQW'(DST_HEIGHT - 1));
	end

	// Position counters; wrap to a new frame after the last source row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dcol_q    <= '0;
			drow_q    <= '0;
			crem_q    <= '0;
			rrem_q    <= '0;
		end else if (accept) begin
			if (!row_end) begin
				src_col_q <= scol + SCW'(1);
				dcol_q    <= dcol_nxt;
				crem_q    <= crem_nxt;
				src_row_q <= srow;
				drow_q    <= drow;
				rrem_q    <= rrem;
			end else begin
				src_col_q <= '0;
				dcol_q    <= '0;
				crem_q    <= '0;
				if (frame_end) begin
					src_row_q <= '0;
					drow_q    <= '0;
					rrem_q    <= '0;
				end else begin
					src_row_q <= srow + SRW'(1);
					drow_q    <= drow_nxt;
					rrem_q    <= rrem_nxt;
				end
			end
		end
	end

endmodule

// File: rtl/rdg_fifo.sv
// Short queue of kept pixels between front and back ends.
// Depends on rdg_pkg.
module rdg_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rdg_pkg::rdg_item_t push_item,
	output logic               full,
	output logic               pop_valid,
	input  logic               pop,
	output rdg_pkg::rdg_item_t pop_item
);
	import rdg_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	rdg_item_t     mem_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_pop;

	assign full      = (cnt_q == (PW + 1)'(QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rd_q];
	assign do_pop    = pop && pop_valid;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + (PW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/rdg_back.sv
// Back end: luma and gamma-corrected display channels, two-stage pipeline.
// Depends on rdg_pkg and rdg_out_if; pulls items from rdg_fifo.
module rdg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rdg_pkg::rdg_item_t in_item,
	rdg_out_if.source          res
);
	import rdg_pkg::*;

	logic [CH_W-1:0]        r5, b5, g5;
	logic [CH_W:0]          g6;
	logic [LUMA_SUM_W-1:0]  sum;
	logic [LUMA_PROD_W-1:0] prod;

	logic                  vld_s1;
	logic [LUMA_SUM_W-1:0] sum_s1;
	logic [CH_W-1:0]       ridx_s1, gidx_s1, bidx_s1;
	logic [POS_W-1:0]      col_s1, row_s1;
	logic                  done_s1;

	logic              out_vld_q;
	logic [GRAY_W-1:0] gray_q;
	logic [CH_W-1:0]   red_q, green_q, blue_q;
	logic [POS_W-1:0]  col_q, row_q;
	logic              done_q;

	logic out_rdy, s1_adv;

	// Stall chain: a stage moves when the one after it is free
	assign out_rdy  = !out_vld_q || res.ready;
	assign s1_adv   = !vld_s1 || out_rdy;
	assign in_ready = s1_adv;

	// Channel split and weighted sum on the widened channels
	always_comb begin
		r5  = in_item.pixel[15:11];
		g6  = in_item.pixel[10:5];
		g5  = in_item.pixel[10:6];
		b5  = in_item.pixel[4:0];
		sum = LUMA_SUM_W'({r5, 3'b000}) * LUMA_SUM_W'(LUMA_WR)
			+ LUMA_SUM_W'({g6, 2'b00}) * LUMA_SUM_W'(LUMA_WG)
			+ LUMA_SUM_W'({b5, 3'b000}) * LUMA_SUM_W'(LUMA_WB);
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_valid) begin
			sum_s1  <= sum;
			ridx_s1 <= disp_index(r5, SCALE_R);
			gidx_s1 <= disp_index(g5, SCALE_G);
			bidx_s1 <= disp_index(b5, SCALE_B);
			col_s1  <= in_item.out_col;
			row_s1  <= in_item.out_row;
			done_s1 <= in_item.frame_done;
		end
	end

	// Divide by 100 through the reciprocal
	assign prod = LUMA_PROD_W'(sum_s1) * LUMA_PROD_W'(LUMA_RECIP);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_rdy) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && vld_s1) begin
			gray_q  <= prod[LUMA_SHIFT +: GRAY_W];
			red_q   <= GAMMA_LUT[ridx_s1];
			green_q <= GAMMA_LUT[gidx_s1];
			blue_q  <= GAMMA_LUT[bidx_s1];
			col_q   <= col_s1;
			row_q   <= row_s1;
			done_q  <= done_s1;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.gray       = gray_q;
	assign res.disp_red   = red_q;
	assign res.disp_green = green_q;
	assign res.disp_blue  = blue_q;
	assign res.out_col    = col_q;
	assign res.out_row    = row_q;
	assign res.frame_done = done_q;

endmodule

// File: rtl/rgb565_downscale_gray_gamma.sv
// RGB565 nearest-neighbour downscaler with luma and gamma display outputs.
// Throughput: one pixel request per cycle while the queue is not full, at most one result per cycle.
// A kept pixel passes through the queue, the stage 1 register and the output register to the result port.
// The rate is set by the position counters, which update on every accepted pixel.
// Reset clears the position counters to a frame start and empties queue and pipeline.
// Depends on rdg_pkg, rdg_in_if, rdg_out_if, rdg_front, rdg_fifo, rdg_back.
module rgb565_downscale_gray_gamma #(
	parameter int SRC_WIDTH  = rdg_pkg::SRC_WIDTH_DEF,
	parameter int SRC_HEIGHT = rdg_pkg::SRC_HEIGHT_DEF,
	parameter int DST_WIDTH  = rdg_pkg::DST_WIDTH_DEF,
	parameter int DST_HEIGHT = rdg_pkg::DST_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rdg_in_if.sink    pix,
	rdg_out_if.source res
);
	import rdg_pkg::*;

	`include "rgb565_downscale_gray_gamma_assert.svh"

	logic      q_push, q_full, q_valid, q_pop;
	rdg_item_t q_item, q_head;

	rdg_front #(
		.SRC_WIDTH (SRC_WIDTH),
		.SRC_HEIGHT(SRC_HEIGHT),
		.DST_WIDTH (DST_WIDTH),
		.DST_HEIGHT(DST_HEIGHT)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.q_push(q_push),
		.q_item(q_item),
		.q_full(q_full)
	);

	rdg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_item),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop      (q_pop),
		.pop_item (q_head)
	);

	rdg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_ready(q_pop),
		.in_item (q_head),
		.res     (res)
	);

	// Never push into a full queue
	`RDG_ASSERT_NOW(a_no_overflow, q_push, !q_full, "push into full queue")

	// The first pixel of a frame always lands on output position zero
	`RDG_ASSERT_NOW(a_frame_origin, pix.valid && pix.ready && pix.frame_start,
		q_push && q_item.out_col == '0 && q_item.out_row == '0,
		"frame start pixel not kept at origin")

	// Last-pixel flag only on the bottom-right output position
	`RDG_ASSERT_NOW(a_done_pos, res.valid && res.frame_done,
		res.out_col == POS_W'(DST_WIDTH - 1) && res.out_row == POS_W'(DST_HEIGHT - 1),
		"frame_done on wrong position")

	// A pushed item makes the queue non-empty next cycle
	`RDG_ASSERT_NEXT(a_push_seen, q_push, q_valid, "pushed item not visible")

endmodule
